/* rtl/falt_pkg.sv */
// Package for the failed-authentication lockout table.
// Holds action codes, configuration register indexes and the entry and result types.
// Used by the channel interfaces and by failed_auth_lockout_table_unit.
package falt_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned END_W   = TIME_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]        THRESHOLD_RST = 8'd5;
  localparam logic [TIME_W-1:0] LOCK_TIME_RST = 32'd300;

  typedef enum logic [1:0] {
    ACT_CHECK   = 2'd0,
    ACT_FAIL    = 2'd1,
    ACT_SUCCESS = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAIL_THRESHOLD = 1'b0,
    REG_LOCKOUT_TIME   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [END_W-1:0] lock_end;
  } entry_t;

  typedef struct packed {
    logic locked;
    logic lockout_started;
    logic no_slot;
  } result_t;

endpackage

/* rtl/falt_ifs.sv */
// Valid/ready channel interfaces for the lockout table.
// Request channel carries action, key and time; result channel carries the flags.
// Depends on falt_pkg for field widths.
interface falt_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [falt_pkg::KEY_W-1:0]    user_key;
  logic [falt_pkg::TIME_W-1:0]   now;

  modport source (output valid, action, user_key, now, input ready);
  modport sink (input valid, action, user_key, now, output ready);
endinterface

interface falt_res_if;
  logic valid;
  logic ready;
  logic locked;
  logic lockout_started;
  logic no_slot;

  modport source (output valid, locked, lockout_started, no_slot, input ready);
  modport sink (input valid, locked, lockout_started, no_slot, output ready);
endinterface

/* rtl/failed_auth_lockout_table_unit.sv */
// Failed-authentication lockout table, top level.
// Depends on falt_pkg and on the channel interfaces in falt_ifs.sv.
//
// Use: every transaction on in_ch names an action (check, fail, success), a
// 64-bit user key and the current time, and yields exactly one transaction on
// out_ch with the flags locked, lockout_started and no_slot. Two registers,
// fail_threshold (index 0) and lockout_time (index 1), are written through
// cfg_we/cfg_idx/cfg_data; the user must write them only while the block is
// idle; the block itself does not enforce this. Entries live in one
// synchronous memory and are allocated in index order and never freed, so a
// fill count marks which entries hold data. A lookup reads the memory one
// entry per cycle until the key matches or the filled part ends. One item is
// handled at a time, and the next one is taken as soon as the result sits in
// the output register. The single memory port's sequential scan sets the rate.
// Reset (rst_n low, synchronous) empties the table at once and restores the
// register defaults of 5 and 300. While out_ch is stalled the result waits in
// its output register; the block takes one more item and holds its result
// until the output register frees.
module failed_auth_lockout_table_unit #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [falt_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [falt_pkg::CFG_DATA_W-1:0]   cfg_data,
  falt_req_if.sink                          in_ch,
  falt_res_if.source                        out_ch
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MOD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r;

  logic [7:0]                      thr_r;
  logic [falt_pkg::TIME_W-1:0]     ltime_r;
  logic [CW-1:0]                   fill_r;
  logic [IW-1:0]                   scan_idx_r;
  logic [IW-1:0]                   ent_idx_r;
  logic                            alloc_r;
  falt_pkg::action_t               action_r;
  logic [falt_pkg::KEY_W-1:0]      key_r;
  logic [falt_pkg::TIME_W-1:0]     now_r;
  logic [falt_pkg::CNT_W-1:0]      cnt_r;
  logic [falt_pkg::END_W-1:0]      end_r;
  falt_pkg::result_t               res_r;
  falt_pkg::result_t               out_res_r;
  logic                            out_valid_r;

  falt_pkg::entry_t                mem [ENTRIES];
  falt_pkg::entry_t                rd_q;
  logic [IW-1:0]                   rd_addr;
  logic                            mem_we;
  falt_pkg::entry_t                wr_data;

  logic                            full;
  logic                            scan_last;
  logic                            in_acc;
  logic                            out_free;
  logic [falt_pkg::CNT_W:0]        cnt_inc;
  logic                            thr_hit;
  logic [falt_pkg::END_W-1:0]      lock_sum;
  logic [falt_pkg::END_W-1:0]      now_ext;
  falt_pkg::result_t               mod_res;

  assign full      = (fill_r == CW'(ENTRIES));
  assign scan_last = ((CW'(scan_idx_r) + CW'(1)) == fill_r);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc    = in_ch.valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.locked          = out_res_r.locked;
  assign out_ch.lockout_started = out_res_r.lockout_started;
  assign out_ch.no_slot         = out_res_r.no_slot;

  // Read address: entry 0 when a lookup starts, then the entry after the one
  // whose data arrives this cycle.
  always_comb begin
    if (state_r == S_SCAN && !scan_last) begin
      rd_addr = scan_idx_r + IW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  // Read-modify-write of the selected entry.
  always_comb begin
    now_ext  = {1'b0, now_r};
    cnt_inc  = {1'b0, cnt_r} + 9'd1;
    thr_hit  = (cnt_inc >= {1'b0, thr_r});
    lock_sum = now_ext + {1'b0, ltime_r};
    wr_data.key      = key_r;
    wr_data.cnt      = cnt_r;
    wr_data.lock_end = end_r;
    mod_res  = '0;
    unique case (action_r)
      falt_pkg::ACT_CHECK: begin
        mod_res.locked = (now_ext < end_r);
      end
      falt_pkg::ACT_FAIL: begin
        if (thr_hit) begin
          wr_data.cnt      = '0;
          wr_data.lock_end = lock_sum;
          mod_res.lockout_started = 1'b1;
        end else begin
          wr_data.cnt = cnt_inc[falt_pkg::CNT_W-1:0];
        end
      end
      falt_pkg::ACT_SUCCESS: begin
        wr_data.cnt      = '0;
        wr_data.lock_end = '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_we = (state_r == S_MOD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ent_idx_r] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= falt_pkg::THRESHOLD_RST;
      ltime_r <= falt_pkg::LOCK_TIME_RST;
    end else if (cfg_we) begin
      unique case (falt_pkg::cfg_reg_t'(cfg_idx))
        falt_pkg::REG_FAIL_THRESHOLD: thr_r   <= cfg_data[7:0];
        falt_pkg::REG_LOCKOUT_TIME:   ltime_r <= cfg_data[falt_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers of the item in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= falt_pkg::action_t'(in_ch.action);
      key_r    <= in_ch.user_key;
      now_r    <= in_ch.now;
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      scan_idx_r  <= '0;
      ent_idx_r   <= '0;
      alloc_r     <= 1'b0;
      cnt_r       <= '0;
      end_r       <= '0;
      res_r       <= '0;
      out_res_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            scan_idx_r <= '0;
            if (falt_pkg::action_t'(in_ch.action) == falt_pkg::ACT_UNUSED) begin
              res_r   <= '0;
              state_r <= S_OUT;
            end else if (fill_r == '0) begin
              // Empty table: allocate entry 0 without a scan.
              ent_idx_r <= '0;
              cnt_r     <= '0;
              end_r     <= '0;
              alloc_r   <= 1'b1;
              state_r   <= S_MOD;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_q.key == key_r) begin
            ent_idx_r <= scan_idx_r;
            cnt_r     <= rd_q.cnt;
            end_r     <= rd_q.lock_end;
            alloc_r   <= 1'b0;
            state_r   <= S_MOD;
          end else if (scan_last) begin
            if (full) begin
              res_r   <= '{locked: 1'b0, lockout_started: 1'b0, no_slot: 1'b1};
              state_r <= S_OUT;
            end else begin
              ent_idx_r <= fill_r[IW-1:0];
              cnt_r     <= '0;
              end_r     <= '0;
              alloc_r   <= 1'b1;
              state_r   <= S_MOD;
            end
          end else begin
            scan_idx_r <= scan_idx_r + IW'(1);
          end
        end
        S_MOD: begin
          if (alloc_r) begin
            fill_r <= fill_r + CW'(1);
          end
          res_r   <= mod_res;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_res_r <= res_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more entries than it has.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  // The fill count only grows, and by one entry at a time.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && fill_r != $past(fill_r) |-> fill_r == $past(fill_r) + CW'(1))
    else $error("fill count changed by other than one");

  // A full-table result can only be reported once every entry is taken.
  a_noslot_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.no_slot |-> full)
    else $error("no_slot reported with free entries");

  // A result never flags both a lock check and a lockout start.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.locked && out_res_r.lockout_started))
    else $error("locked and lockout_started both set");

  // An entry is written back only below the fill mark, or at it when the item allocates.
  a_write_idx: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(ent_idx_r) < fill_r) || (alloc_r && CW'(ent_idx_r) == fill_r))
    else $error("write to an entry outside the filled range");

endmodule

/* tb/tb_failed_auth_lockout_table_unit.sv */
// Self-checking testbench for failed_auth_lockout_table_unit.
// Drives lockout requests over valid/ready channels and checks every result flag
// against a table model kept here. Depends on falt_pkg and the falt_ifs channels.
module tb_failed_auth_lockout_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 32;
  localparam int NUM_HOT = 8;
  localparam int NUM_WARM = 24;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    falt_pkg::action_t                 act;
    logic [falt_pkg::KEY_W-1:0]        key;
    logic [falt_pkg::TIME_W-1:0]       now;
  } auth_req_t;

  typedef struct {
    auth_req_t          req;
    falt_pkg::result_t  res;
    int                 seq;
  } verdict_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                            cfg_we = 1'b0;
  falt_pkg::cfg_reg_t              cfg_idx = falt_pkg::REG_FAIL_THRESHOLD;
  logic [falt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic      in_valid = 1'b0;
  auth_req_t in_item = '0;
  logic      out_ready = 1'b0;

  falt_req_if req_ch ();
  falt_res_if res_ch ();

  assign req_ch.valid    = in_valid;
  assign req_ch.action   = in_item.act;
  assign req_ch.user_key = in_item.key;
  assign req_ch.now      = in_item.now;
  assign res_ch.ready    = out_ready;

  failed_auth_lockout_table_unit #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_ch   (req_ch),
    .out_ch  (res_ch)
  );

  // Table model and register copies.
  bit                          ent_used [ENTRIES];
  logic [falt_pkg::KEY_W-1:0]  ent_key  [ENTRIES];
  logic [falt_pkg::CNT_W-1:0]  ent_cnt  [ENTRIES];
  logic [falt_pkg::END_W-1:0]  ent_end  [ENTRIES];
  logic [7:0]                  cfg_threshold = falt_pkg::THRESHOLD_RST;
  logic [falt_pkg::TIME_W-1:0] cfg_lock_time = falt_pkg::LOCK_TIME_RST;

  auth_req_t auth_req_q[$];
  verdict_t  verdict_q[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 1;
  int n_lockouts = 0;
  int n_locked = 0;
  int n_full = 0;
  int idle_cycles = 0;

  logic [falt_pkg::KEY_W-1:0]  hot_keys  [NUM_HOT];
  logic [falt_pkg::KEY_W-1:0]  warm_keys [NUM_WARM];
  logic [falt_pkg::TIME_W-1:0] wall_time;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic falt_pkg::result_t predict_lockout(auth_req_t r);
    int                 slot;
    int                 free_slot;
    logic [8:0]         cnt_next;
    falt_pkg::result_t  res;
    res = '0;
    slot = -1;
    free_slot = -1;
    if (r.act == falt_pkg::ACT_UNUSED) return res;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && ent_used[i] && ent_key[i] == r.key) slot = i;
      if (!ent_used[i] && free_slot < 0) free_slot = i;
    end
    if (slot < 0 && free_slot >= 0) begin
      slot = free_slot;
      ent_used[slot] = 1'b1;
      ent_key[slot] = r.key;
      ent_cnt[slot] = '0;
      ent_end[slot] = '0;
    end
    if (slot < 0) begin
      res.no_slot = 1'b1;
      return res;
    end
    case (r.act)
      falt_pkg::ACT_CHECK: begin
        res.locked = ({1'b0, r.now} < ent_end[slot]);
      end
      falt_pkg::ACT_FAIL: begin
        cnt_next = {1'b0, ent_cnt[slot]} + 9'd1;
        // A threshold of zero is met by every failure.
        if (cnt_next >= {1'b0, cfg_threshold}) begin
          ent_end[slot] = {1'b0, r.now} + {1'b0, cfg_lock_time};
          ent_cnt[slot] = '0;
          res.lockout_started = 1'b1;
        end else begin
          ent_cnt[slot] = cnt_next[7:0];
        end
      end
      default: begin
        ent_cnt[slot] = '0;
        ent_end[slot] = '0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  task automatic queue_req(falt_pkg::action_t act, logic [falt_pkg::KEY_W-1:0] key,
                           logic [falt_pkg::TIME_W-1:0] now);
    auth_req_t r;
    r.act = act;
    r.key = key;
    r.now = now;
    auth_req_q.push_back(r);
    n_queued++;
  endtask

  task automatic write_reg(falt_pkg::cfg_reg_t idx, logic [falt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == falt_pkg::REG_FAIL_THRESHOLD) cfg_threshold = data[7:0];
    else cfg_lock_time = data;
  endtask

  task automatic wait_idle();
    while (n_results < n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A run of failures a few ticks apart, then checks at the last failure, just before
  // and at the lockout end, sometimes followed by a success that should unlock.
  task automatic lockout_attempts(logic [falt_pkg::KEY_W-1:0] key, int fails);
    logic [falt_pkg::TIME_W-1:0] t_fail;
    for (int i = 0; i < fails; i++) begin
      wall_time += $urandom_range(0, 3);
      queue_req(falt_pkg::ACT_FAIL, key, wall_time);
    end
    t_fail = wall_time;
    queue_req(falt_pkg::ACT_CHECK, key, t_fail);
    queue_req(falt_pkg::ACT_CHECK, key, t_fail + cfg_lock_time - 1);
    queue_req(falt_pkg::ACT_CHECK, key, t_fail + cfg_lock_time);
    if ($urandom_range(0, 2) == 0) begin
      queue_req(falt_pkg::ACT_SUCCESS, key, t_fail + 1);
      queue_req(falt_pkg::ACT_CHECK, key, t_fail + 1);
    end
    wall_time += $urandom_range(0, 8);
  endtask

  task automatic random_traffic(int n_items);
    int start;
    int sel;
    int cap;
    logic [falt_pkg::KEY_W-1:0] key;
    logic [falt_pkg::TIME_W-1:0] now;
    start = n_queued;
    while (n_queued - start < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        cap = (cfg_threshold < 9) ? int'(cfg_threshold) + 1 : 10;
        lockout_attempts(hot_keys[$urandom_range(0, NUM_HOT - 1)], $urandom_range(1, cap));
      end else if (sel < 87) begin
        key = ($urandom_range(0, 1) == 0) ? hot_keys[$urandom_range(0, NUM_HOT - 1)]
                                           : warm_keys[$urandom_range(0, NUM_WARM - 1)];
        now = ($urandom_range(0, 1) == 0) ? wall_time : $urandom;
        queue_req(falt_pkg::action_t'($urandom_range(0, 3)), key, now);
      end else begin
        // Unknown user: allocates an entry, or hits the full table.
        queue_req(falt_pkg::action_t'($urandom_range(0, 2)), {$urandom, $urandom}, $urandom);
      end
    end
  endtask

  task automatic run_phase(logic [7:0] thr, logic [falt_pkg::TIME_W-1:0] lt, int burst_fails,
                           int n_items);
    // Upper data bits are not part of the threshold register.
    write_reg(falt_pkg::REG_FAIL_THRESHOLD, ($urandom & 32'hFFFF_FF00) | {24'd0, thr});
    write_reg(falt_pkg::REG_LOCKOUT_TIME, lt);
    n_settings++;
    if (burst_fails > 0) lockout_attempts(hot_keys[$urandom_range(0, NUM_HOT - 1)], burst_fails);
    random_traffic(n_items);
    wait_idle();
  endtask

  // Stimulus and run control.
  initial begin
    logic [falt_pkg::KEY_W-1:0] fresh_key;
    for (int i = 0; i < NUM_HOT; i++) hot_keys[i] = {$urandom, $urandom};
    for (int i = 0; i < NUM_WARM; i++) warm_keys[i] = {$urandom, $urandom};
    wall_time = $urandom;
    fresh_key = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset defaults: key extremes, time at its maximum so the
    // lockout end needs the extra bit, every action and the unused code.
    queue_req(falt_pkg::ACT_CHECK, '0, '0);
    for (int i = 0; i < 5; i++) queue_req(falt_pkg::ACT_FAIL, '1, 32'hFFFF_FFFF);
    queue_req(falt_pkg::ACT_CHECK, '1, 32'hFFFF_FFFF);
    queue_req(falt_pkg::ACT_SUCCESS, '1, 32'hFFFF_FFFF);
    queue_req(falt_pkg::ACT_CHECK, '1, 32'hFFFF_FFFF);
    queue_req(falt_pkg::ACT_UNUSED, fresh_key, 32'h0000_1234);
    queue_req(falt_pkg::ACT_SUCCESS, fresh_key, 32'h0000_5678);
    for (int i = 0; i < 4; i++) queue_req(falt_pkg::ACT_FAIL, '0, 32'd100);
    queue_req(falt_pkg::ACT_SUCCESS, '0, 32'd101);
    queue_req(falt_pkg::ACT_FAIL, '0, 32'd102);
    queue_req(falt_pkg::ACT_CHECK, '0, 32'd102);
    wait_idle();

    run_phase(8'd1, 32'd1, 0, 90);
    run_phase(8'd3, 32'd40, 0, 90);
    run_phase(8'd0, 32'd0, 0, 90);
    run_phase(8'd255, 32'hFFFF_FFFF, 255, 20);
    run_phase(8'($urandom_range(2, 8)), 32'($urandom_range(1, 1000)), 0, 90);
    run_phase(falt_pkg::THRESHOLD_RST, falt_pkg::LOCK_TIME_RST, 0, 90);

    repeat (40) @(posedge clk);
    $display("Summary: %0d lockout requests checked under %0d register settings.",
             n_accepted, n_settings);
    $display("Summary: %0d lockouts began, %0d checks saw a lock, %0d replies saw a full table.",
             n_lockouts, n_locked, n_full);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive_req
    logic busy;
    verdict_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && req_ch.ready) begin
        v.req = in_item;
        v.res = predict_lockout(in_item);
        v.seq = n_accepted;
        verdict_q.push_back(v);
        n_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (auth_req_q.size() != 0) begin
          in_item <= auth_req_q.pop_front();
          busy = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 6);
              gap_left = $urandom_range(1, 12);
            end
          end
        end
      end
      in_valid <= busy;
    end
  end

  // Result receiver: ready follows a rotating pattern that changes now and then.
  logic [31:0] stall_pat = '1;
  int pat_left = 0;

  always @(posedge clk) begin : drive_ready
    logic [31:0] pat;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      pat = stall_pat;
      if (pat_left == 0) begin
        pat = ($urandom_range(0, 2) == 0) ? '1 : ($urandom | 32'd1);
        pat_left = $urandom_range(16, 80);
      end else begin
        pat_left--;
      end
      out_ready <= pat[0];
      stall_pat <= {pat[0], pat[31:1]};
    end
  end

  // Result monitor.
  always @(posedge clk) begin : check_res
    verdict_t v;
    if (rst_n && res_ch.valid && out_ready) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        report_mismatch("result transaction with no request outstanding");
      end else begin
        v = verdict_q.pop_front();
        if (res_ch.locked !== v.res.locked ||
            res_ch.lockout_started !== v.res.lockout_started ||
            res_ch.no_slot !== v.res.no_slot) begin
          report_mismatch($sformatf(
            "txn %0d %s key %h now %h: locked/started/no_slot %b%b%b, expected %b%b%b",
            v.seq, v.req.act.name(), v.req.key, v.req.now,
            res_ch.locked, res_ch.lockout_started, res_ch.no_slot,
            v.res.locked, v.res.lockout_started, v.res.no_slot));
        end
        if (v.res.lockout_started) n_lockouts++;
        if (v.res.locked) n_locked++;
        if (v.res.no_slot) n_full++;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && req_ch.ready) || (res_ch.valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
rtl/falt_pkg.sv
rtl/falt_ifs.sv
rtl/failed_auth_lockout_table_unit.sv
tb/tb_failed_auth_lockout_table_unit.sv
